[sv/sawbc_pkg.sv]
// Package: constants, opcodes and address helpers for the write-back cache.
`default_nettype none
package sawbc_pkg;
	localparam int ADDR_BITS = 12;
	localparam int SET_BITS  = 2;
	localparam int WORD_BITS = 1;
	localparam int WAYS      = 4;

	localparam int NSETS     = 1 << SET_BITS;
	localparam int NLINES    = NSETS * WAYS;
	localparam int BLKW      = 1 << WORD_BITS;
	localparam int MEMW      = 1 << (ADDR_BITS - 2);
	localparam int TAG_SHIFT = SET_BITS + WORD_BITS + 2;
	localparam int TAG_W     = ADDR_BITS - TAG_SHIFT;
	localparam int SET_W     = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int LN_W      = (NLINES > 1) ? $clog2(NLINES) : 1;
	localparam int WCNT_W    = (WORD_BITS > 0) ? WORD_BITS : 1;
	localparam int LD_AW     = LN_W + WORD_BITS;
	localparam int LD_DEPTH  = NLINES * BLKW;
	localparam int MEM_AW    = ADDR_BITS - 2;
	localparam logic [31:0] ADDR_LIMIT = 32'(1) << ADDR_BITS;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;

	function automatic logic [LN_W-1:0] line_idx(input logic [SET_W-1:0] s,
			input logic [WAY_W-1:0] w);
		logic [31:0] t;
		t = 32'(s) * 32'(WAYS) + 32'(w);
		return t[LN_W-1:0];
	endfunction

	function automatic logic [SET_W-1:0] set_of(input logic [15:0] a);
		logic [31:0] t;
		t = (32'(a) >> (WORD_BITS + 2)) & 32'(NSETS - 1);
		return t[SET_W-1:0];
	endfunction

	function automatic logic [TAG_W-1:0] tag_of(input logic [15:0] a);
		logic [31:0] t;
		t = 32'(a) >> TAG_SHIFT;
		return t[TAG_W-1:0];
	endfunction

	function automatic logic [WCNT_W-1:0] word_of(input logic [15:0] a);
		logic [31:0] t;
		t = (32'(a) >> 2) & 32'(BLKW - 1);
		return t[WCNT_W-1:0];
	endfunction

	function automatic logic [LD_AW-1:0] ld_addr(input logic [LN_W-1:0] ln,
			input logic [WCNT_W-1:0] w);
		logic [31:0] t;
		t = (32'(ln) << WORD_BITS) | (32'(w) & 32'(BLKW - 1));
		return t[LD_AW-1:0];
	endfunction

	function automatic logic [MEM_AW-1:0] wb_addr(input logic [TAG_W-1:0] tg,
			input logic [SET_W-1:0] s, input logic [WCNT_W-1:0] w);
		logic [31:0] t;
		t = (32'(tg) << (SET_BITS + WORD_BITS))
			| ((32'(s) & 32'(NSETS - 1)) << WORD_BITS)
			| (32'(w) & 32'(BLKW - 1));
		return t[MEM_AW-1:0];
	endfunction

	function automatic logic [MEM_AW-1:0] fill_addr(input logic [15:0] a,
			input logic [WCNT_W-1:0] w);
		logic [31:0] t;
		t = ((32'(a) >> 2) & ~32'(BLKW - 1)) | (32'(w) & 32'(BLKW - 1));
		return t[MEM_AW-1:0];
	endfunction
endpackage
`default_nettype wire

[sv/sawbc_ram.sv]
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module sawbc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

[sv/set_assoc_writeback_cache_lru.sv]
// Top level: byte-wide set-associative write-back cache with LRU replacement.
// Input requests arrive on s_tvalid/s_tready/s_tdata, one result per request
// leaves on m_tvalid/m_tready/m_tdata. One request is handled at a time.
// Steps, from acceptance to the result register:
//   hit: a tag scan of one way at a time, a pick step, then a
//   read-modify-write of the line data RAM and the result step; a miss
//   adds a read and a write per block word for the fill, a victim check
//   when every way is valid, and a read and a write per word if a dirty
//   victim is written back; flush checks each line in turn, and each dirty
//   line is written back word by word and then invalidated;
//   out-of-range and unused requests go straight to the result.
// The single-port line data RAM and backing RAM set these steps.
// After reset the backing RAM is cleared, one word a cycle, over its
// whole depth, during which s_tready stays low.
// A result waits in the output register while m_tready is low; the next
// request may be accepted meanwhile but its result waits until the
// register drains.
`default_nettype none
module set_assoc_writeback_cache_lru (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // operation[1:0], address[17:2], write_data[25:18]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata   // read_data[7:0], status[8], hit[9]
);
	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_LOOK = 4'd2;
	localparam logic [3:0] S_PICK = 4'd3;
	localparam logic [3:0] S_VICT = 4'd4;
	localparam logic [3:0] S_WRD  = 4'd5;
	localparam logic [3:0] S_WWR  = 4'd6;
	localparam logic [3:0] S_FRD  = 4'd7;
	localparam logic [3:0] S_FWR  = 4'd8;
	localparam logic [3:0] S_TCH  = 4'd9;
	localparam logic [3:0] S_ACC  = 4'd10;
	localparam logic [3:0] S_FCHK = 4'd11;
	localparam logic [3:0] S_FCLR = 4'd12;
	localparam logic [3:0] S_DONE = 4'd13;

	logic [3:0] state_q;
	logic [1:0] op_q;
	logic [15:0] addr_q;
	logic [7:0] wd_q;
	logic [sawbc_pkg::SET_W-1:0] set_q;
	logic [sawbc_pkg::WAY_W-1:0] way_q, hway_q, iway_q, lway_q;
	logic hit_q, inv_q;
	logic [31:0] lts_q, count_q;
	logic [sawbc_pkg::LN_W-1:0] sel_q;
	logic [sawbc_pkg::WCNT_W-1:0] wcnt_q;
	logic [sawbc_pkg::MEM_AW:0] clr_q;
	logic [7:0] res_rd_q;
	logic res_st_q, res_hit_q;
	logic [7:0] o_rd_q;
	logic o_st_q, o_hit_q, o_valid_q;

	logic [sawbc_pkg::TAG_W-1:0] mtag_q [sawbc_pkg::NLINES];
	logic [sawbc_pkg::NLINES-1:0] mvalid_q, mdirty_q;
	logic [31:0] mts_q [sawbc_pkg::NLINES];

	logic [sawbc_pkg::LN_W-1:0] scan_ln, m_idx;
	logic [sawbc_pkg::TAG_W-1:0] r_tag;
	logic r_valid, r_dirty;
	logic [31:0] r_ts;

	logic ld_we, bk_we;
	logic [sawbc_pkg::LD_AW-1:0] ld_a;
	logic [sawbc_pkg::MEM_AW-1:0] bk_a;
	logic [31:0] ld_wd, bk_wd, ld_rd, bk_rd;

	logic s_acc, last_way, last_line, last_word, out_free;
	logic [4:0] bsh;
	logic [31:0] merged;

	assign scan_ln = sawbc_pkg::line_idx(set_q, way_q);
	assign m_idx = (state_q == S_LOOK || state_q == S_FCHK) ? scan_ln : sel_q;
	assign r_tag = mtag_q[m_idx];
	assign r_valid = mvalid_q[m_idx];
	assign r_dirty = mdirty_q[m_idx];
	assign r_ts = mts_q[m_idx];

	assign s_tready = (state_q == S_IDLE);
	assign s_acc = s_tvalid && s_tready;
	assign last_way = (way_q == sawbc_pkg::WAY_W'(sawbc_pkg::WAYS - 1));
	assign last_line = last_way && (set_q == sawbc_pkg::SET_W'(sawbc_pkg::NSETS - 1));
	assign last_word = (wcnt_q == sawbc_pkg::WCNT_W'(sawbc_pkg::BLKW - 1));
	assign out_free = !o_valid_q || m_tready;
	assign bsh = {addr_q[1:0], 3'b000};
	assign merged = (ld_rd & ~(32'h0000_00ff << bsh)) | (32'(wd_q) << bsh);

	always_comb begin
		ld_we = 1'b0;
		ld_a = sawbc_pkg::ld_addr(sel_q, wcnt_q);
		ld_wd = bk_rd;
		bk_we = 1'b0;
		bk_a = sawbc_pkg::fill_addr(addr_q, wcnt_q);
		bk_wd = ld_rd;
		case (state_q)
			S_CLR: begin
				bk_we = 1'b1;
				bk_a = clr_q[sawbc_pkg::MEM_AW-1:0];
				bk_wd = '0;
			end
			S_WWR: begin
				bk_we = 1'b1;
				bk_a = sawbc_pkg::wb_addr(r_tag, set_q, wcnt_q);
			end
			S_FWR: begin
				ld_we = 1'b1;
			end
			S_TCH: begin
				ld_a = sawbc_pkg::ld_addr(sel_q, sawbc_pkg::word_of(addr_q));
			end
			S_ACC: begin
				ld_a = sawbc_pkg::ld_addr(sel_q, sawbc_pkg::word_of(addr_q));
				ld_we = (op_q == sawbc_pkg::OP_WRITE);
				ld_wd = merged;
			end
			default: begin
			end
		endcase
	end

	sawbc_ram #(.WIDTH(32), .DEPTH(sawbc_pkg::LD_DEPTH)) u_line_ram (
		.clk(clk), .we(ld_we), .addr(ld_a), .wdata(ld_wd), .rdata(ld_rd)
	);

	sawbc_ram #(.WIDTH(32), .DEPTH(sawbc_pkg::MEMW)) u_back_ram (
		.clk(clk), .we(bk_we), .addr(bk_a), .wdata(bk_wd), .rdata(bk_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			count_q <= '0;
			o_valid_q <= 1'b0;
			mvalid_q <= '0;
			mdirty_q <= '0;
			for (int i = 0; i < sawbc_pkg::NLINES; i++) begin
				mtag_q[i] <= '0;
				mts_q[i] <= '0;
			end
		end else begin
			if (o_valid_q && m_tready && state_q != S_DONE) begin
				o_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (sawbc_pkg::MEM_AW + 1)'(sawbc_pkg::MEMW - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_acc) begin
						op_q <= s_tdata[1:0];
						addr_q <= s_tdata[17:2];
						wd_q <= s_tdata[25:18];
						set_q <= (s_tdata[1:0] == sawbc_pkg::OP_FLUSH) ? '0
							: sawbc_pkg::set_of(s_tdata[17:2]);
						way_q <= '0;
						hit_q <= 1'b0;
						inv_q <= 1'b0;
						res_rd_q <= '0;
						res_st_q <= 1'b0;
						res_hit_q <= 1'b0;
						case (s_tdata[1:0])
							sawbc_pkg::OP_READ, sawbc_pkg::OP_WRITE: begin
								if (32'(s_tdata[17:2]) >= sawbc_pkg::ADDR_LIMIT) begin
									res_st_q <= 1'b1;
									state_q <= S_DONE;
								end else begin
									count_q <= count_q + 32'd1;
									state_q <= S_LOOK;
								end
							end
							sawbc_pkg::OP_FLUSH: begin
								state_q <= S_FCHK;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_LOOK: begin
					if (r_valid && r_tag == sawbc_pkg::tag_of(addr_q) && !hit_q) begin
						hit_q <= 1'b1;
						hway_q <= way_q;
					end
					if (!r_valid && !inv_q) begin
						inv_q <= 1'b1;
						iway_q <= way_q;
					end
					if (way_q == '0 || r_ts < lts_q) begin
						lway_q <= way_q;
						lts_q <= r_ts;
					end
					if (last_way) begin
						state_q <= S_PICK;
					end else begin
						way_q <= way_q + 1'b1;
					end
				end
				S_PICK: begin
					wcnt_q <= '0;
					if (hit_q) begin
						sel_q <= sawbc_pkg::line_idx(set_q, hway_q);
						state_q <= S_TCH;
					end else if (inv_q) begin
						sel_q <= sawbc_pkg::line_idx(set_q, iway_q);
						state_q <= S_FRD;
					end else begin
						sel_q <= sawbc_pkg::line_idx(set_q, lway_q);
						state_q <= S_VICT;
					end
				end
				S_VICT: begin
					state_q <= r_dirty ? S_WRD : S_FRD;
				end
				S_WRD: begin
					state_q <= S_WWR;
				end
				S_WWR: begin
					if (last_word) begin
						wcnt_q <= '0;
						state_q <= (op_q == sawbc_pkg::OP_FLUSH) ? S_FCLR : S_FRD;
					end else begin
						wcnt_q <= wcnt_q + 1'b1;
						state_q <= S_WRD;
					end
				end
				S_FRD: begin
					state_q <= S_FWR;
				end
				S_FWR: begin
					wcnt_q <= wcnt_q + 1'b1;
					if (last_word) begin
						mvalid_q[sel_q] <= 1'b1;
						mdirty_q[sel_q] <= 1'b0;
						mtag_q[sel_q] <= sawbc_pkg::tag_of(addr_q);
						state_q <= S_TCH;
					end else begin
						state_q <= S_FRD;
					end
				end
				S_TCH: begin
					mts_q[sel_q] <= count_q;
					state_q <= S_ACC;
				end
				S_ACC: begin
					res_hit_q <= hit_q;
					if (op_q == sawbc_pkg::OP_READ) begin
						res_rd_q <= 8'(ld_rd >> bsh);
					end else begin
						mdirty_q[sel_q] <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_FCHK: begin
					sel_q <= scan_ln;
					wcnt_q <= '0;
					if (r_dirty) begin
						state_q <= S_WRD;
					end else if (last_line) begin
						state_q <= S_DONE;
					end else if (last_way) begin
						way_q <= '0;
						set_q <= set_q + 1'b1;
					end else begin
						way_q <= way_q + 1'b1;
					end
				end
				S_FCLR: begin
					mvalid_q[sel_q] <= 1'b0;
					mdirty_q[sel_q] <= 1'b0;
					mtag_q[sel_q] <= '0;
					mts_q[sel_q] <= count_q + 32'd1;
					count_q <= count_q + 32'd1;
					if (last_line) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_FCHK;
						if (last_way) begin
							way_q <= '0;
							set_q <= set_q + 1'b1;
						end else begin
							way_q <= way_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						o_valid_q <= 1'b1;
						o_rd_q <= res_rd_q;
						o_st_q <= res_st_q;
						o_hit_q <= res_hit_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata = {6'd0, o_hit_q, o_st_q, o_rd_q};
endmodule
`default_nettype wire

[sv/sawbc_checker.sv]
// Checker: port-level properties of the cache, bound to the top level.
`default_nettype none
module sawbc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [31:0] s_tdata,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] |-> m_tdata[7:0] == 8'd0 && !m_tdata[9])
		else $error("out-of-range result carries data or hit");

	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

	a_flush_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[1:0] == 2'd2 |=> !s_tready)
		else $error("flush finished without a scan");
endmodule

bind set_assoc_writeback_cache_lru sawbc_checker u_sawbc_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

[verif/set_assoc_writeback_cache_lru_test.sv]
// Testbench for the write-back LRU cache: directed and random requests against a behavioural model.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_writeback_cache_lru_test;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1500000;

	typedef struct packed {
		logic       hit;
		logic       oor;
		logic [7:0] rdata;
	} cache_resp_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	set_assoc_writeback_cache_lru u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	logic [sawbc_pkg::TAG_W-1:0] mdl_tag [sawbc_pkg::NLINES];
	logic             mdl_valid [sawbc_pkg::NLINES];
	logic             mdl_dirty [sawbc_pkg::NLINES];
	logic [31:0]      mdl_stamp [sawbc_pkg::NLINES];
	logic [31:0]      mdl_line [sawbc_pkg::NLINES*sawbc_pkg::BLKW];
	logic [31:0]      mdl_mem [sawbc_pkg::MEMW];
	logic [31:0]      mdl_count;

	cache_resp_t resp_q[$];
	int errors = 0;
	int n_req = 0;
	int n_resp = 0;
	int n_hit = 0;
	int n_flush = 0;
	longint cycles = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic void evict_block(input int ln);
		int s;
		s = ln / sawbc_pkg::WAYS;
		for (int w = 0; w < sawbc_pkg::BLKW; w++)
			mdl_mem[((int'(mdl_tag[ln]) << (sawbc_pkg::SET_BITS + sawbc_pkg::WORD_BITS))
				| (s << sawbc_pkg::WORD_BITS) | w) & (sawbc_pkg::MEMW - 1)]
				= mdl_line[ln*sawbc_pkg::BLKW + w];
	endfunction

	function automatic cache_resp_t predict_access(input logic [1:0] op,
			input logic [15:0] a, input logic [7:0] wd);
		cache_resp_t r;
		int s, base, ln, wi, sh, first;
		logic [sawbc_pkg::TAG_W-1:0] tg;
		bit found, got;
		r = '0;
		if (op == sawbc_pkg::OP_FLUSH) begin
			for (int i = 0; i < sawbc_pkg::NLINES; i++)
				if (mdl_dirty[i]) begin
					evict_block(i);
					mdl_dirty[i] = 0;
					mdl_valid[i] = 0;
					mdl_tag[i] = '0;
					mdl_count = mdl_count + 1;
					mdl_stamp[i] = mdl_count;
				end
			return r;
		end
		if (op == OP_UNUSED) return r;
		if (32'(a) >= sawbc_pkg::ADDR_LIMIT) begin
			r.oor = 1'b1;
			return r;
		end
		mdl_count = mdl_count + 1;
		s = (int'(a) >> (sawbc_pkg::WORD_BITS + 2)) & (sawbc_pkg::NSETS - 1);
		tg = sawbc_pkg::TAG_W'(int'(a) >> sawbc_pkg::TAG_SHIFT);
		base = s * sawbc_pkg::WAYS;
		found = 0;
		ln = base;
		for (int i = 0; i < sawbc_pkg::WAYS; i++)
			if (!found && mdl_valid[base+i] && mdl_tag[base+i] == tg) begin
				ln = base + i;
				found = 1;
			end
		if (found) r.hit = 1'b1;
		else begin
			got = 0;
			for (int i = 0; i < sawbc_pkg::WAYS; i++)
				if (!got && !mdl_valid[base+i]) begin
					ln = base + i;
					got = 1;
				end
			if (!got) begin
				ln = base;
				for (int i = 1; i < sawbc_pkg::WAYS; i++)
					if (mdl_stamp[base+i] < mdl_stamp[ln]) ln = base + i;
				if (mdl_dirty[ln]) evict_block(ln);
			end
			first = (int'(a) >> 2) & ~(sawbc_pkg::BLKW - 1);
			for (int w = 0; w < sawbc_pkg::BLKW; w++)
				mdl_line[ln*sawbc_pkg::BLKW + w] = mdl_mem[(first + w) & (sawbc_pkg::MEMW - 1)];
			mdl_valid[ln] = 1;
			mdl_dirty[ln] = 0;
			mdl_tag[ln] = tg;
		end
		mdl_stamp[ln] = mdl_count;
		wi = ln * sawbc_pkg::BLKW + ((int'(a) >> 2) & (sawbc_pkg::BLKW - 1));
		sh = 8 * (int'(a) & 3);
		if (op == sawbc_pkg::OP_READ) r.rdata = 8'(mdl_line[wi] >> sh);
		else begin
			mdl_line[wi] = (mdl_line[wi] & ~(32'hFF << sh)) | (32'(wd) << sh);
			mdl_dirty[ln] = 1;
		end
		return r;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_req(input logic [1:0] op, input logic [15:0] a, input logic [7:0] wd);
		int g;
		g = gap_len();
		repeat ((g > 0) ? g : 1) @(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, wd, a, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		resp_q.push_back(predict_access(op, a, wd));
		n_req++;
		if (op == sawbc_pkg::OP_FLUSH) n_flush++;
		@(negedge clk) s_tvalid <= 1'b0;
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 49) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(5, 40)) @(negedge clk);
			end else begin
				m_tready <= ($urandom_range(0, 99) < 60) ? 1'b1
					: ($urandom_range(0, 9) == 0 ? 1'b0 : 1'b1);
			end
		end
	end

	always @(posedge clk) begin
		cache_resp_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = cache_resp_t'(m_tdata[9:0]);
			n_resp++;
			if (got.hit) n_hit++;
			if (resp_q.size() == 0) begin
				$display("%0t unexpected response %h", $time, m_tdata);
				errors++;
			end else begin
				want = resp_q.pop_front();
				if (got.rdata !== want.rdata) begin
					$display("%0t read_data exp %h got %h", $time, want.rdata, got.rdata);
					errors++;
				end
				if (got.oor !== want.oor) begin
					$display("%0t status exp %b got %b", $time, want.oor, got.oor);
					errors++;
				end
				if (got.hit !== want.hit) begin
					$display("%0t hit exp %b got %b", $time, want.hit, got.hit);
					errors++;
				end
			end
		end
	end

	task automatic drain();
		while (resp_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] addr_in(input int s, input int tg);
		return 16'((tg << sawbc_pkg::TAG_SHIFT) | (s << (sawbc_pkg::WORD_BITS + 2))
			| $urandom_range(0, 4*sawbc_pkg::BLKW - 1));
	endfunction

	task automatic test_extremes();
		send_req(sawbc_pkg::OP_READ, 16'h0000, 8'h00);
		send_req(sawbc_pkg::OP_WRITE, 16'h0000, 8'hFF);
		send_req(sawbc_pkg::OP_READ, 16'h0000, 8'h00);
		send_req(sawbc_pkg::OP_WRITE, 16'h0FFF, 8'hA5);
		send_req(sawbc_pkg::OP_READ, 16'h0FFF, 8'hFF);
		send_req(sawbc_pkg::OP_READ, 16'h1000, 8'h00);
		send_req(sawbc_pkg::OP_WRITE, 16'hFFFF, 8'hFF);
		send_req(OP_UNUSED, 16'hFFFF, 8'hFF);
		send_req(sawbc_pkg::OP_FLUSH, 16'h1234, 8'h5A);
		send_req(sawbc_pkg::OP_READ, 16'h0FFF, 8'h00);
	endtask

	task automatic test_eviction();
		// five tags into one set force an LRU victim, dirty ones written back
		for (int t = 0; t < sawbc_pkg::WAYS + 1; t++)
			send_req(sawbc_pkg::OP_WRITE, addr_in(1, t), 8'(t + 1));
		for (int t = 0; t < sawbc_pkg::WAYS + 1; t++)
			send_req(sawbc_pkg::OP_READ, addr_in(1, t), 8'h00);
		send_req(sawbc_pkg::OP_FLUSH, 16'h0000, 8'h00);
		for (int t = 0; t < 3; t++) send_req(sawbc_pkg::OP_READ, addr_in(1, t), 8'h00);
	endtask

	task automatic test_random(input int count);
		logic [1:0] op;
		logic [15:0] a;
		int p;
		for (int i = 0; i < count; i++) begin
			p = $urandom_range(0, 99);
			op = (p < 48) ? sawbc_pkg::OP_READ : (p < 94) ? sawbc_pkg::OP_WRITE
				: (p < 97) ? sawbc_pkg::OP_FLUSH : OP_UNUSED;
			if ($urandom_range(0, 19) == 0) a = 16'($urandom_range(0, 65535));
			else if ($urandom_range(0, 3) == 0)
				a = 16'($urandom_range(0, sawbc_pkg::ADDR_LIMIT - 1));
			else a = addr_in($urandom_range(0, sawbc_pkg::NSETS - 1), $urandom_range(0, 7));
			send_req(op, a, 8'($urandom_range(0, 255)));
			if (i == count / 2) drain();
		end
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		for (int i = 0; i < sawbc_pkg::NLINES; i++) begin
			mdl_tag[i] = '0; mdl_valid[i] = 0; mdl_dirty[i] = 0; mdl_stamp[i] = '0;
		end
		for (int i = 0; i < sawbc_pkg::NLINES*sawbc_pkg::BLKW; i++) mdl_line[i] = '0;
		for (int i = 0; i < sawbc_pkg::MEMW; i++) mdl_mem[i] = '0;
		mdl_count = '0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_extremes();
		test_eviction();
		test_random(1430);
		drain();
		repeat (200) @(posedge clk);
		$display("%0d requests (%0d flushes), %0d responses, %0d hits", n_req, n_flush,
			n_resp, n_hit);
		if (errors == 0 && resp_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d errors, %0d responses outstanding", errors, resp_q.size());
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
`default_nettype wire

[set_assoc_writeback_cache_lru.f]
sv/sawbc_pkg.sv
sv/sawbc_ram.sv
sv/set_assoc_writeback_cache_lru.sv
sv/sawbc_checker.sv
verif/set_assoc_writeback_cache_lru_test.sv
